// ----- hdl/tilt_balance_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// tilt balance sequencer assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// switched off while reset is high
// ----------------------------------------------------------------------------
`ifndef TILT_BALANCE_SEQUENCER_ASSERT_SVH
`define TILT_BALANCE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define TBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt balance sequencer: same-cycle check failed");

// next-cycle implication
`define TBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt balance sequencer: next-cycle check failed");

`endif

// ----- hdl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbs_pkg
// types and constants shared by the tilt balance sequencer modules
// ----------------------------------------------------------------------------
package tbs_pkg;

  // sequencer phases
  typedef enum logic [1:0] {
    PH_APPROACH = 2'd0,
    PH_CLIMB    = 2'd1,
    PH_HOLD     = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  // register indexes of the configuration port
  localparam logic [2:0] REG_FAST_SPEED       = 3'd0;
  localparam logic [2:0] REG_SLOW_SPEED       = 3'd1;
  localparam logic [2:0] REG_STATION_ANGLE    = 3'd2;
  localparam logic [2:0] REG_LEVEL_ANGLE      = 3'd3;
  localparam logic [2:0] REG_DWELL_TICKS      = 3'd4;
  localparam logic [2:0] REG_CORRECTION_SPEED = 3'd5;

  // field widths
  localparam int unsigned SPEED_W = 15;
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned DWELL_W = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned PITCH_W = 13;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 15;

  // qualifying counter saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // register reset values
  localparam logic [SPEED_W-1:0] FAST_SPEED_RST       = 15'd19661;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST       = 15'd3277;
  localparam logic [ANGLE_W-1:0] STATION_ANGLE_RST    = 12'd176;
  localparam logic [ANGLE_W-1:0] LEVEL_ANGLE_RST      = 12'd152;
  localparam logic [DWELL_W-1:0] DWELL_TICKS_RST      = 8'd10;
  localparam logic [SPEED_W-1:0] CORRECTION_SPEED_RST = 15'd2376;

  // configuration register set
  typedef struct packed {
    logic [SPEED_W-1:0] fast_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [ANGLE_W-1:0] station_angle;
    logic [ANGLE_W-1:0] level_angle;
    logic [DWELL_W-1:0] dwell_ticks;
    logic [SPEED_W-1:0] correction_speed;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    phase_t             phase;
    logic [COUNT_W-1:0] count;
  } seq_state_t;

  // outcome of one tick
  typedef struct packed {
    seq_state_t                state_next;
    logic signed [DRIVE_W-1:0] speed;
  } step_t;

endpackage

// ----- hdl/tbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tbs_cfg_regs
// configuration register bank, one write request per cycle, unknown
// indexes are dropped
// ----------------------------------------------------------------------------
module tbs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tbs_pkg::cfg_t                      cfg
);
  import tbs_pkg::*;

  // writes never stall
  assign cfg_ready = 1'b1;

  // register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_speed       <= FAST_SPEED_RST;
      cfg.slow_speed       <= SLOW_SPEED_RST;
      cfg.station_angle    <= STATION_ANGLE_RST;
      cfg.level_angle      <= LEVEL_ANGLE_RST;
      cfg.dwell_ticks      <= DWELL_TICKS_RST;
      cfg.correction_speed <= CORRECTION_SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FAST_SPEED:       cfg.fast_speed       <= cfg_data[SPEED_W-1:0];
        REG_SLOW_SPEED:       cfg.slow_speed       <= cfg_data[SPEED_W-1:0];
        REG_STATION_ANGLE:    cfg.station_angle    <= cfg_data[ANGLE_W-1:0];
        REG_LEVEL_ANGLE:      cfg.level_angle      <= cfg_data[ANGLE_W-1:0];
        REG_DWELL_TICKS:      cfg.dwell_ticks      <= cfg_data[DWELL_W-1:0];
        REG_CORRECTION_SPEED: cfg.correction_speed <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/tbs_step_logic.sv -----
// ----------------------------------------------------------------------------
// tbs_step_logic
// per-tick phase sequencing: qualifying compares, counter update, phase
// advance and drive speed selection
// ----------------------------------------------------------------------------
module tbs_step_logic (
  input  logic signed [tbs_pkg::PITCH_W-1:0] pitch,
  input  tbs_pkg::seq_state_t                state,
  input  tbs_pkg::cfg_t                      cfg,
  output tbs_pkg::step_t                     step
);
  import tbs_pkg::*;

  logic [PITCH_W-1:0]        mag;
  logic signed [PITCH_W:0]   pitch_w;
  logic signed [PITCH_W:0]   lvl_w;
  logic                      hit;
  logic [COUNT_W-1:0]        count_bump;
  logic                      advance;

  // magnitude and widened operands
  always_comb begin
    mag     = pitch[PITCH_W-1] ? PITCH_W'(-pitch) : PITCH_W'(pitch);
    pitch_w = {pitch[PITCH_W-1], pitch};
    lvl_w   = $signed({2'b00, cfg.level_angle});
  end

  // phase condition for this tick
  always_comb begin
    unique case (state.phase)
      PH_APPROACH: hit = mag > {1'b0, cfg.station_angle};
      PH_CLIMB:    hit = mag < {1'b0, cfg.level_angle};
      PH_HOLD:     hit = {mag, 1'b0} <= {2'b00, cfg.level_angle};
      PH_DONE:     hit = 1'b0;
      default:     hit = 1'b0;
    endcase
  end

  // saturating counter and advance test
  always_comb begin
    count_bump = (hit && state.count < COUNT_MAX) ? state.count + 9'd1 : state.count;
    advance    = (state.phase != PH_DONE) && (count_bump > {1'b0, cfg.dwell_ticks});
  end

  // next state
  always_comb begin
    step.state_next.count = advance ? '0 : count_bump;
    step.state_next.phase = state.phase;
    if (advance) begin
      unique case (state.phase)
        PH_APPROACH: step.state_next.phase = PH_CLIMB;
        PH_CLIMB:    step.state_next.phase = PH_HOLD;
        PH_HOLD:     step.state_next.phase = PH_DONE;
        PH_DONE:     step.state_next.phase = PH_DONE;
        default:     step.state_next.phase = PH_DONE;
      endcase
    end
  end

  // drive speed
  always_comb begin
    step.speed = '0;
    unique case (state.phase)
      PH_APPROACH: begin
        step.speed = advance ? $signed({1'b0, cfg.slow_speed})
                             : $signed({1'b0, cfg.fast_speed});
      end
      PH_CLIMB: begin
        step.speed = advance ? '0 : $signed({1'b0, cfg.slow_speed});
      end
      PH_HOLD: begin
        priority if (advance) begin
          step.speed = '0;
        end else if (pitch_w >= lvl_w) begin
          step.speed = DRIVE_W'(-$signed({1'b0, cfg.correction_speed}));
        end else if (pitch_w <= -lvl_w) begin
          step.speed = $signed({1'b0, cfg.correction_speed});
        end else begin
          step.speed = '0;
        end
      end
      PH_DONE: step.speed = '0;
      default: step.speed = '0;
    endcase
  end

endmodule

// ----- hdl/tilt_balance_sequencer.sv -----
// ----------------------------------------------------------------------------
// tilt_balance_sequencer
// four-phase tilt balancing sequencer: approach, climb, hold, done
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_ready carries one pitch sample per request
//   (signed, 1/16 degree). Output channel out_valid / out_ready returns one
//   request per sample: signed Q1.15 drive_speed and the phase after the tick.
//   Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
//   one register per request; it is always ready. Write only while idle.
//   Pipeline: a sample passes through the input register, then the result
//   register, before out_valid rises. Throughput: one sample per cycle while
//   out_ready is high, set by the single pass of compares and counter update
//   between the two registers.
//   Reset: phase returns to approach, the counter clears, registers take
//   their defaults and both pipeline stages empty.
//   Stall: while out_ready is low a full result register holds; the input
//   register still takes one more sample, after which in_ready drops until
//   the output drains.
// ----------------------------------------------------------------------------
module tilt_balance_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tbs_pkg::PITCH_W-1:0]  pitch,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tbs_pkg::DRIVE_W-1:0]  drive_speed,
  output logic [1:0]                          phase
);
  import tbs_pkg::*;
  `include "tilt_balance_sequencer_assert.svh"

  cfg_t                      cfg;
  seq_state_t                state;
  step_t                     step;
  logic                      s1_valid;
  logic signed [PITCH_W-1:0] s1_pitch;
  logic                      s1_move;
  phase_t                    out_phase;

  // configuration registers
  tbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-tick logic
  tbs_step_logic u_step (
    .pitch (s1_pitch),
    .state (state),
    .cfg   (cfg),
    .step  (step)
  );

  // pipeline flow
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pitch <= pitch;
    end
  end

  // sequencer state, updated as each sample is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_APPROACH;
      state.count <= '0;
    end else if (s1_move) begin
      state <= step.state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      drive_speed <= step.speed;
      out_phase   <= step.state_next.phase;
    end
  end

  assign phase = out_phase;

  // checks
  `TBS_ASSERT_NEXT(a_done_stays, clk, rst, state.phase == PH_DONE, state.phase == PH_DONE)
  `TBS_ASSERT_NEXT(a_move_fills_out, clk, rst, s1_move, out_valid)
  `TBS_ASSERT_NOW(a_done_no_drive, clk, rst, out_valid && out_phase == PH_DONE,
                  drive_speed == '0)
  `TBS_ASSERT_NOW(a_empty_ready, clk, rst, !s1_valid, in_ready)

endmodule
